@@ rtl/core/mgre_pkg.sv @@
// mgre_pkg: shared types, constants and color packing for the glyph row expander
// depends on nothing; imported by every module of the block
package mgre_pkg;

	localparam int GLYPH_WIDTH = 8;
	localparam int COL_W = $clog2(GLYPH_WIDTH);
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(GLYPH_WIDTH - 1);
	localparam int QUEUE_DEPTH = 2;

	localparam int ADDR_W = 48;
	localparam int WORD_W = 32;
	localparam int PITCH_W = 18;
	localparam int DIM_W = 16;
	localparam int FMT_W = 9;
	localparam int RGB_W = 24;
	localparam int CFG_IDX_W = 3;
	localparam int MAX_CHAN = 8;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DRAWING_ENABLED = 3'd0,
		REG_FRAME_BASE      = 3'd1,
		REG_LINE_PITCH      = 3'd2,
		REG_SCREEN_WIDTH    = 3'd3,
		REG_SCREEN_HEIGHT   = 3'd4,
		REG_RED_FORMAT      = 3'd5,
		REG_GREEN_FORMAT    = 3'd6,
		REG_BLUE_FORMAT     = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic               drawing_enabled;
		logic [ADDR_W-1:0]  frame_base;
		logic [PITCH_W-1:0] line_pitch;
		logic [DIM_W-1:0]   screen_width;
		logic [DIM_W-1:0]   screen_height;
		logic [FMT_W-1:0]   red_format;
		logic [FMT_W-1:0]   green_format;
		logic [FMT_W-1:0]   blue_format;
	} cfg_t;

	// one accepted row, ready for expansion
	typedef struct packed {
		logic [ADDR_W-1:0]      start_addr;
		logic [WORD_W-1:0]      fore_word;
		logic [WORD_W-1:0]      back_word;
		logic [GLYPH_WIDTH-1:0] bits;
	} qent_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} qstat_t;

	function automatic logic [WORD_W-1:0] place_channel(
		input logic [7:0] chan,
		input logic [FMT_W-1:0] fmt
	);
		logic [3:0] size;
		logic [4:0] shift;
		logic [WORD_W-1:0] narrowed;
		size = fmt[3:0];
		shift = fmt[8:4];
		if (size > 4'(MAX_CHAN)) begin
			size = 4'(MAX_CHAN);
		end
		narrowed = WORD_W'(chan) >> (4'(MAX_CHAN) - size);
		return narrowed << shift;
	endfunction

	function automatic logic [WORD_W-1:0] pack_rgb(
		input logic [RGB_W-1:0] rgb,
		input cfg_t cfg
	);
		return place_channel(rgb[23:16], cfg.red_format)
			| place_channel(rgb[15:8], cfg.green_format)
			| place_channel(rgb[7:0], cfg.blue_format);
	endfunction

endpackage

@@ rtl/core/mgre_front.sv @@
// mgre_front: accepts rows, drops those not to be drawn, packs colors and forms the start address
// depends on mgre_pkg; feeds mgre_queue
module mgre_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mgre_pkg::cfg_t                  cfg,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [mgre_pkg::DIM_W-1:0]      origin_x,
	input  logic [mgre_pkg::DIM_W-1:0]      origin_y,
	input  logic [7:0]                      glyph_rows,
	input  logic [7:0]                      row_index,
	input  logic [mgre_pkg::GLYPH_WIDTH-1:0] row_bits,
	input  logic [mgre_pkg::RGB_W-1:0]      fore_rgb,
	input  logic [mgre_pkg::RGB_W-1:0]      back_rgb,
	input  mgre_pkg::qstat_t                qstat,
	output logic                            push,
	output mgre_pkg::qent_t                 push_data
);
	import mgre_pkg::*;

	localparam int PROD_W = DIM_W + 1 + PITCH_W;

	logic                   valid_s1;
	logic [DIM_W-1:0]       ox_s1;
	logic [DIM_W-1:0]       oy_s1;
	logic [7:0]             rows_s1;
	logic [7:0]             ri_s1;
	logic [GLYPH_WIDTH-1:0] bits_s1;
	logic [RGB_W-1:0]       fore_s1;
	logic [RGB_W-1:0]       back_s1;

	logic                   valid_s2;
	logic [PROD_W-1:0]      prod_s2;
	logic [DIM_W-1:0]       ox_s2;
	logic [GLYPH_WIDTH-1:0] bits_s2;
	logic [WORD_W-1:0]      fore_s2;
	logic [WORD_W-1:0]      back_s2;

	logic              keep;
	logic [DIM_W:0]    row_y;
	logic              s1_move;
	logic              s2_move;

	// row is drawn only when drawing is enabled, the whole glyph is on screen and the row is inside the glyph
	always_comb begin
		keep = cfg.drawing_enabled
			&& ({1'b0, ox_s1} + (DIM_W+1)'(GLYPH_WIDTH) <= {1'b0, cfg.screen_width})
			&& ({1'b0, oy_s1} + (DIM_W+1)'(rows_s1) <= {1'b0, cfg.screen_height})
			&& (ri_s1 < rows_s1);
		row_y = {1'b0, oy_s1} + (DIM_W+1)'(ri_s1);
	end

	assign s2_move = !valid_s2 || !qstat.full;
	assign s1_move = !valid_s1 || !keep || s2_move;
	assign in_ready = s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_move) begin
				valid_s1 <= in_valid;
			end
			if (s2_move) begin
				valid_s2 <= valid_s1 && keep;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			ox_s1   <= origin_x;
			oy_s1   <= origin_y;
			rows_s1 <= glyph_rows;
			ri_s1   <= row_index;
			bits_s1 <= row_bits;
			fore_s1 <= fore_rgb;
			back_s1 <= back_rgb;
		end
		if (s2_move) begin
			prod_s2 <= PROD_W'(row_y) * PROD_W'(cfg.line_pitch);
			ox_s2   <= ox_s1;
			bits_s2 <= bits_s1;
			fore_s2 <= pack_rgb(fore_s1, cfg);
			back_s2 <= pack_rgb(back_s1, cfg);
		end
	end

	always_comb begin
		push = valid_s2 && !qstat.full;
		push_data.start_addr = cfg.frame_base + ADDR_W'(prod_s2)
			+ ADDR_W'({ox_s2, 2'b00});
		push_data.fore_word = fore_s2;
		push_data.back_word = back_s2;
		push_data.bits = bits_s2;
	end

endmodule

@@ rtl/core/mgre_queue.sv @@
// mgre_queue: short register queue between the front and the back
// depends on mgre_pkg
module mgre_queue #(
	parameter int DEPTH = mgre_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mgre_pkg::qent_t   push_data,
	input  logic              pop,
	output mgre_pkg::qent_t   head,
	output mgre_pkg::qstat_t  qstat
);
	import mgre_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	qent_t             entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign head = entries_q[rd_ptr_q];
	assign qstat.full = (count_q == CNT_W'(DEPTH));
	assign qstat.not_empty = (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < CNT_W'(DEPTH)))
		else $error("push into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("pop from an empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count lost a push");

endmodule

@@ rtl/core/mgre_back.sv @@
// mgre_back: walks the columns of the head row and drives the write beats
// depends on mgre_pkg; reads from mgre_queue
module mgre_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mgre_pkg::qent_t               head,
	input  mgre_pkg::qstat_t              qstat,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mgre_pkg::ADDR_W-1:0]   write_address,
	output logic [mgre_pkg::WORD_W-1:0]   pixel_word,
	output logic                          last_pixel
);
	import mgre_pkg::*;

	logic [COL_W-1:0]  col_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] write_address_q;
	logic [WORD_W-1:0] pixel_word_q;
	logic              last_pixel_q;
	logic              load;

	assign load = qstat.not_empty && (!out_valid_q || out_ready);
	assign pop = load && (col_q == LAST_COL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				col_q       <= (col_q == LAST_COL) ? '0 : col_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// bit 7 of the pattern is column 0
	always_ff @(posedge clk) begin
		if (load) begin
			write_address_q <= head.start_addr + ADDR_W'({col_q, 2'b00});
			pixel_word_q    <= head.bits[LAST_COL - col_q] ? head.fore_word : head.back_word;
			last_pixel_q    <= (col_q == LAST_COL);
		end
	end

	assign out_valid = out_valid_q;
	assign write_address = write_address_q;
	assign pixel_word = pixel_word_q;
	assign last_pixel = last_pixel_q;

endmodule

@@ rtl/core/mono_glyph_row_expander.sv @@
// mono_glyph_row_expander: top level, configuration registers and the front/queue/back chain
// depends on mgre_pkg, mgre_front, mgre_queue, mgre_back
//
// usage
// - input channel (in_valid/in_ready): one beat is one glyph row with its origin, glyph
//   height, row index, 8-bit pattern and foreground/background rgb
// - output channel (out_valid/out_ready): one beat is one 32-bit pixel write, byte address
//   plus packed color; eight beats per drawn row, leftmost pixel first, last_pixel on the eighth
// - rows that are off screen, past the glyph height, or sent while drawing is disabled are
//   dropped in the front and give no beats
// - configuration: cfg_write with cfg_index/cfg_data updates one register;
//   write only while the block is idle
// - path: an accepted row goes through the front's s1 and s2 stages and the queue into the
//   back's output register; dropped rows pass the front at one per cycle
// - throughput: one write beat per cycle while rows are queued and out_ready is high
// - the front keeps accepting while beats of earlier rows are still waiting; when the
//   receiver stalls, the output register holds, the queue fills, then in_ready drops
// - reset clears the configuration registers (drawing disabled) and empties the pipeline and queue
module mono_glyph_row_expander #(
	parameter int QUEUE_DEPTH = mgre_pkg::QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [mgre_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mgre_pkg::ADDR_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mgre_pkg::DIM_W-1:0]          origin_x,
	input  logic [mgre_pkg::DIM_W-1:0]          origin_y,
	input  logic [7:0]                          glyph_rows,
	input  logic [7:0]                          row_index,
	input  logic [mgre_pkg::GLYPH_WIDTH-1:0]    row_bits,
	input  logic [mgre_pkg::RGB_W-1:0]          fore_rgb,
	input  logic [mgre_pkg::RGB_W-1:0]          back_rgb,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mgre_pkg::ADDR_W-1:0]         write_address,
	output logic [mgre_pkg::WORD_W-1:0]         pixel_word,
	output logic                                last_pixel
);
	import mgre_pkg::*;

	cfg_t   cfg_q;
	qent_t  push_data;
	qent_t  head;
	qstat_t qstat;
	logic   push;
	logic   pop;

	// configuration registers, all zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_DRAWING_ENABLED: cfg_q.drawing_enabled <= cfg_data[0];
				REG_FRAME_BASE:      cfg_q.frame_base <= cfg_data;
				REG_LINE_PITCH:      cfg_q.line_pitch <= cfg_data[PITCH_W-1:0];
				REG_SCREEN_WIDTH:    cfg_q.screen_width <= cfg_data[DIM_W-1:0];
				REG_SCREEN_HEIGHT:   cfg_q.screen_height <= cfg_data[DIM_W-1:0];
				REG_RED_FORMAT:      cfg_q.red_format <= cfg_data[FMT_W-1:0];
				REG_GREEN_FORMAT:    cfg_q.green_format <= cfg_data[FMT_W-1:0];
				REG_BLUE_FORMAT:     cfg_q.blue_format <= cfg_data[FMT_W-1:0];
				default:             cfg_q <= cfg_q;
			endcase
		end
	end

	// front: accept, classify, pack colors, form start address
	mgre_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.origin_x   (origin_x),
		.origin_y   (origin_y),
		.glyph_rows (glyph_rows),
		.row_index  (row_index),
		.row_bits   (row_bits),
		.fore_rgb   (fore_rgb),
		.back_rgb   (back_rgb),
		.qstat      (qstat),
		.push       (push),
		.push_data  (push_data)
	);

	// rows waiting for expansion
	mgre_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	// back: one pixel write beat per cycle while rows are queued and out_ready is high
	mgre_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.qstat         (qstat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.write_address (write_address),
		.pixel_word    (pixel_word),
		.last_pixel    (last_pixel)
	);

endmodule
